// ===== sv/capm_pkg.sv =====
// Package: widths, register indexes, fixed-point helpers for the attitude mixer.
`default_nettype none
package capm_pkg;

  localparam int VW = 32;
  localparam int FB = 16;
  localparam int DTW = 17;
  localparam int GW = 31;
  localparam int NCFG = 8;
  localparam int AW = 5;

  typedef logic signed [VW-1:0] val_t;

  localparam logic signed [VW:0] VMAX = (VW+1)'((64'd1 << (VW-1)) - 1);
  localparam logic signed [VW:0] VMIN = -VMAX - (VW+1)'(1);

  typedef enum logic [2:0] {
    REG_PERIOD = 3'd0, REG_ANGLE_P = 3'd1, REG_TILT_P = 3'd2, REG_TILT_I = 3'd3,
    REG_TILT_D = 3'd4, REG_YAW_P = 3'd5, REG_YAW_I = 3'd6, REG_ILIM = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ANGLE, ST_ERR, ST_MULA, ST_DIV, ST_MULB, ST_MIX, ST_OUT
  } state_t;

  // lane start controls
  typedef struct packed {
    logic start_div;
    logic take_err;
  } lane_ctl_t;

  // saturate a wide signed value to the value word
  function automatic val_t sat66(input logic signed [65:0] v);
    if (v > 66'(VMAX)) sat66 = val_t'(VMAX);
    else if (v < 66'(VMIN)) sat66 = val_t'(VMIN);
    else sat66 = v[VW-1:0];
  endfunction

  // fixed multiply, truncate toward zero, saturate
  function automatic val_t fx_mul(input val_t a, input logic [GW-1:0] b);
    logic [VW-1:0] m;
    logic [VW+GW-1:0] p;
    logic [VW+GW-1:0] q;
    m = a[VW-1] ? VW'(-a) : VW'(a);
    p = m * b;
    q = p >> FB;
    if (a[VW-1]) begin
      if (q >= (VW+GW)'(64'd1 << (VW-1))) fx_mul = val_t'(VMIN);
      else fx_mul = -val_t'(q[VW-1:0]);
    end else begin
      if (q > (VW+GW)'(VMAX)) fx_mul = val_t'(VMAX);
      else fx_mul = val_t'(q[VW-1:0]);
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/capm_lane.sv =====
// One rate PID lane: error, clamped integral, serial derivative divide, sum.
`default_nettype none
module capm_lane (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire capm_pkg::lane_ctl_t    ctl,
  input  wire logic                   mul_b,
  input  wire capm_pkg::val_t         sp,
  input  wire capm_pkg::val_t         meas,
  input  wire logic [capm_pkg::DTW-1:0] dt,
  input  wire logic [capm_pkg::GW-1:0]  kp,
  input  wire logic [capm_pkg::GW-1:0]  ki,
  input  wire logic [capm_pkg::GW-1:0]  kd,
  input  wire logic [capm_pkg::GW-1:0]  ilim,
  output capm_pkg::val_t              loop_out
);
  import capm_pkg::*;

  localparam int NW = VW + FB;
  localparam int CW = $clog2(NW + 1);

  val_t integ_r, last_r, err_r, pterm_r, iterm_r, out_r;
  val_t diff_sat_r;
  logic [NW-1:0] num_r, quo_r;
  logic [DTW:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic neg_r, zero_r;

  logic signed [65:0] e_w, in_w, d_w;
  val_t err_w, in_sat, in_clamp, der_w;
  logic [DTW:0] rem_sh;

  // error and next integral
  always_comb begin
    e_w = 66'(sp) - 66'(meas);
    err_w = sat66(e_w);
    in_w = 66'(integ_r) + 66'(fx_mul(err_r, GW'(dt)));
    in_sat = sat66(in_w);
    in_clamp = in_sat;
    if (in_sat > val_t'({1'b0, ilim})) in_clamp = val_t'({1'b0, ilim});
    if (in_sat < -val_t'({1'b0, ilim})) in_clamp = -val_t'({1'b0, ilim});
    d_w = 66'(err_r) - 66'(last_r);
    rem_sh = {rem_r[DTW-1:0], num_r[NW-1]};
  end

  // derivative from quotient
  always_comb begin
    if (zero_r) der_w = '0;
    else if (dt == '0) der_w = neg_r ? val_t'(VMIN) : val_t'(VMAX);
    else if (neg_r) begin
      if (quo_r >= NW'(64'd1 << (VW-1))) der_w = val_t'(VMIN);
      else der_w = -val_t'(quo_r[VW-1:0]);
    end else begin
      if (quo_r > NW'(VMAX)) der_w = val_t'(VMAX);
      else der_w = val_t'(quo_r[VW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      last_r <= '0;
      cnt_r <= '0;
    end else begin
      if (ctl.take_err) err_r <= err_w;
      if (ctl.start_div) begin
        // integral update (still clamped at zero period), derivative setup
        integ_r <= in_clamp;
        last_r <= err_r;
        zero_r <= (d_w == '0);
        neg_r <= d_w[65];
        num_r <= NW'(d_w[65] ? -d_w : d_w) << FB;
        quo_r <= '0;
        rem_r <= '0;
        cnt_r <= CW'(NW);
        pterm_r <= fx_mul(err_r, kp);
      end else if (cnt_r != '0) begin
        // one restoring divide step
        num_r <= num_r << 1;
        if (rem_sh >= {1'b0, dt}) begin
          rem_r <= rem_sh - {1'b0, dt};
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
      end
      if (mul_b) begin
        iterm_r <= fx_mul(integ_r, ki);
        diff_sat_r <= fx_mul(sat66(66'(der_w)), kd);
      end
      out_r <= sat66(66'(pterm_r) + 66'(iterm_r) + 66'(diff_sat_r));
    end
  end

  assign loop_out = out_r;
endmodule
`default_nettype wire

// ===== sv/capm_mixer.sv =====
// X mixer: four saturated motor commands from three loop outputs.
`default_nettype none
module capm_mixer (
  input  wire logic           clk,
  input  wire logic           load,
  input  wire capm_pkg::val_t r,
  input  wire capm_pkg::val_t p,
  input  wire capm_pkg::val_t y,
  output capm_pkg::val_t      fl,
  output capm_pkg::val_t      fr,
  output capm_pkg::val_t      rl,
  output capm_pkg::val_t      rr
);
  import capm_pkg::*;

  localparam logic signed [65:0] BASE = 66'(sat66(66'(1000) <<< FB));
  val_t fl_r, fr_r, rl_r, rr_r;

  always_ff @(posedge clk) begin
    if (load) begin
      fl_r <= sat66(BASE + 66'(r) + 66'(p) - 66'(y));
      fr_r <= sat66(BASE - 66'(r) + 66'(p) + 66'(y));
      rl_r <= sat66(BASE + 66'(r) - 66'(p) + 66'(y));
      rr_r <= sat66(BASE - 66'(r) - 66'(p) - 66'(y));
    end
  end

  assign fl = fl_r;
  assign fr = fr_r;
  assign rl = rl_r;
  assign rr = rr_r;
endmodule
`default_nettype wire

// ===== sv/cascaded_attitude_pid_mixer_unit.sv =====
// Top level: config registers, sequencer, three rate lanes and mixer.
//  channel | direction | handshake
//  in_*    | input     | in_valid / in_stall
//  out_*   | output    | out_valid / out_stall
//  cfg_*   | APB slave | psel/penable/pwrite, pready high
// The 48-step serial dt divide in each lane sets the time per item; the
// three lanes divide in parallel.
// Synchronous active-low reset clears state and integrals and loads default config registers.
// A finished item waits in the output register; a new item is taken once
// the result has moved in, once the last one is delivered or being taken.
`default_nettype none
module cascaded_attitude_pid_mixer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_roll_setpoint,
  input  wire logic [31:0] in_pitch_setpoint,
  input  wire logic [31:0] in_yaw_rate_setpoint,
  input  wire logic [31:0] in_roll_angle,
  input  wire logic [31:0] in_pitch_angle,
  input  wire logic [31:0] in_roll_gyro,
  input  wire logic [31:0] in_pitch_gyro,
  input  wire logic [31:0] in_yaw_gyro,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_motor_front_left,
  output logic [31:0]      out_motor_front_right,
  output logic [31:0]      out_motor_rear_left,
  output logic [31:0]      out_motor_rear_right,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import capm_pkg::*;

  localparam int NW = VW + FB;
  localparam logic [5:0] DIV_WAIT = 6'(NW);

  logic [DTW-1:0] dt_r;
  logic [GW-1:0] kang_r, ktp_r, kti_r, ktd_r, kyp_r, kyi_r, ilim_r;
  val_t rsp_r, psp_r, ysp_r, rang_r, pang_r, rg_r, pg_r, yg_r, rt_r, pt_r;
  state_t st_r, st_nxt;
  logic [5:0] cnt_r;
  logic out_valid_r;
  lane_ctl_t ctl;
  logic mul_b, mix_load, in_acc;
  val_t r_out, p_out, y_out, fl, fr, rl, rr;
  reg_idx_t widx;

  assign cfg_pready = 1'b1;
  assign widx = reg_idx_t'(cfg_paddr[4:2]);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DTW'(164); kang_r <= GW'(294912); ktp_r <= GW'(9830);
      kti_r <= GW'(3277); ktd_r <= GW'(655); kyp_r <= GW'(29491);
      kyi_r <= GW'(6554); ilim_r <= GW'(26214400);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      case (widx)
        REG_PERIOD:  dt_r <= cfg_pwdata[DTW-1:0];
        REG_ANGLE_P: kang_r <= cfg_pwdata[GW-1:0];
        REG_TILT_P:  ktp_r <= cfg_pwdata[GW-1:0];
        REG_TILT_I:  kti_r <= cfg_pwdata[GW-1:0];
        REG_TILT_D:  ktd_r <= cfg_pwdata[GW-1:0];
        REG_YAW_P:   kyp_r <= cfg_pwdata[GW-1:0];
        REG_YAW_I:   kyi_r <= cfg_pwdata[GW-1:0];
        REG_ILIM:    ilim_r <= cfg_pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (widx)
      REG_PERIOD:  cfg_prdata = 32'(dt_r);
      REG_ANGLE_P: cfg_prdata = 32'(kang_r);
      REG_TILT_P:  cfg_prdata = 32'(ktp_r);
      REG_TILT_I:  cfg_prdata = 32'(kti_r);
      REG_TILT_D:  cfg_prdata = 32'(ktd_r);
      REG_YAW_P:   cfg_prdata = 32'(kyp_r);
      REG_YAW_I:   cfg_prdata = 32'(kyi_r);
      REG_ILIM:    cfg_prdata = 32'(ilim_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_acc) st_nxt = ST_ANGLE;
      ST_ANGLE: st_nxt = ST_ERR;
      ST_ERR:   st_nxt = ST_MULA;
      ST_MULA:  st_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == DIV_WAIT) st_nxt = ST_MULB;
      ST_MULB:  st_nxt = ST_MIX;
      ST_MIX:   st_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl.take_err = (st_r == ST_ERR);
    ctl.start_div = (st_r == ST_MULA);
    mul_b = (st_r == ST_MULB);
    mix_load = (st_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= (st_r == ST_DIV) ? cnt_r + 6'd1 : '0;
      if (mix_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // input capture and angle loops
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rsp_r <= in_roll_setpoint; psp_r <= in_pitch_setpoint;
      ysp_r <= in_yaw_rate_setpoint; rang_r <= in_roll_angle;
      pang_r <= in_pitch_angle; rg_r <= in_roll_gyro;
      pg_r <= in_pitch_gyro; yg_r <= in_yaw_gyro;
    end
    if (st_r == ST_ANGLE) begin
      rt_r <= fx_mul(sat66(66'(rsp_r) - 66'(rang_r)), kang_r);
      pt_r <= fx_mul(sat66(66'(psp_r) - 66'(pang_r)), kang_r);
    end
  end

  capm_lane u_roll (.clk, .rst_n, .ctl, .mul_b, .sp(rt_r), .meas(rg_r), .dt(dt_r),
    .kp(ktp_r), .ki(kti_r), .kd(ktd_r), .ilim(ilim_r), .loop_out(r_out));
  capm_lane u_pitch (.clk, .rst_n, .ctl, .mul_b, .sp(pt_r), .meas(pg_r), .dt(dt_r),
    .kp(ktp_r), .ki(kti_r), .kd(ktd_r), .ilim(ilim_r), .loop_out(p_out));
  capm_lane u_yaw (.clk, .rst_n, .ctl, .mul_b, .sp(ysp_r), .meas(yg_r), .dt(dt_r),
    .kp(kyp_r), .ki(kyi_r), .kd('0), .ilim(ilim_r), .loop_out(y_out));

  capm_mixer u_mix (.clk, .load(mix_load), .r(r_out), .p(p_out), .y(y_out),
    .fl, .fr, .rl, .rr);

  assign out_valid = out_valid_r;
  assign out_motor_front_left = fl;
  assign out_motor_front_right = fr;
  assign out_motor_rear_left = rl;
  assign out_motor_rear_right = rr;
endmodule
`default_nettype wire

// ===== tb/cascaded_attitude_pid_mixer_unit_test.sv =====
// Testbench: random and directed control ticks checked against a bit-true attitude predictor.
module cascaded_attitude_pid_mixer_unit_test;
  import capm_pkg::*;

  localparam int MAX_PERIOD = 65536;

  typedef struct {
    logic [31:0] roll_set, pitch_set, yaw_set, roll_ang, pitch_ang, roll_g, pitch_g, yaw_g;
  } tick_t;

  typedef struct {
    logic [31:0] fl, fr, rl, rr;
  } motors_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_roll_setpoint = '0, in_pitch_setpoint = '0, in_yaw_rate_setpoint = '0;
  logic [31:0] in_roll_angle = '0, in_pitch_angle = '0, in_roll_gyro = '0;
  logic [31:0] in_pitch_gyro = '0, in_yaw_gyro = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [31:0] out_motor_front_left, out_motor_front_right;
  logic [31:0] out_motor_rear_left, out_motor_rear_right;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  cascaded_attitude_pid_mixer_unit u_dut (.*);

  always #4 clk = ~clk;

  // predictor state and register shadow
  longint unsigned dt_q, kang, ktp, kti, ktd, kyp, kyi, ilim;
  longint roll_int, roll_last, pitch_int, pitch_last, yaw_int, yaw_last;

  tick_t   pending_ticks[$];
  motors_t expected_motors[$];
  int errors = 0;
  bit gaps_on = 1'b1;

  localparam longint VMAG = 64'sd1 << 31;
  localparam longint VTOP = VMAG - 1;
  localparam longint VBOT = -VMAG;

  function automatic longint clip(longint v);
    if (v > VTOP) return VTOP;
    if (v < VBOT) return VBOT;
    return v;
  endfunction

  function automatic longint signed_mag(bit neg, longint unsigned m);
    if (m > VMAG) m = VMAG;
    if (neg) return -longint'(m);
    return (m > VTOP) ? VTOP : longint'(m);
  endfunction

  function automatic longint qmul(longint a, longint unsigned b);
    longint unsigned m, ph, pl, r;
    m = (a < 0) ? longint'(-a) : a;
    ph = (m >> 24) * b;
    pl = (m & 64'hFFFFFF) * b;
    if (ph > (VMAG >> 8)) r = VMAG;
    else r = (ph << 8) + (pl >> 16);
    return signed_mag(a < 0, r);
  endfunction

  function automatic longint qdiv(longint d, longint unsigned p);
    longint unsigned m, q, r;
    if (d == 0) return 0;
    if (p == 0) return (d > 0) ? VTOP : VBOT;
    m = (d < 0) ? longint'(-d) : d;
    q = m / p;
    r = m % p;
    if (q > (VMAG >> 16)) return signed_mag(d < 0, VMAG);
    return signed_mag(d < 0, (q << 16) + ((r << 16) / p));
  endfunction

  function automatic longint rate_pid(longint sp, longint meas, ref longint integ,
                                      ref longint last, input longint unsigned kp,
                                      longint unsigned ki, longint unsigned kd);
    longint err, acc, der;
    err = clip(sp - meas);
    acc = clip(integ + qmul(err, dt_q));
    if (acc > longint'(ilim)) acc = ilim;
    if (acc < -longint'(ilim)) acc = -longint'(ilim);
    integ = acc;
    der = qdiv(err - last, dt_q);
    last = err;
    return clip(qmul(err, kp) + qmul(acc, ki) + qmul(der, kd));
  endfunction

  function automatic logic [31:0] motor_word(longint v);
    return 32'(clip(v));
  endfunction

  function automatic motors_t predict_motors(tick_t t);
    longint rt, pt, r, p, y, base;
    motors_t m;
    rt = qmul(clip(longint'($signed(t.roll_set)) - longint'($signed(t.roll_ang))), kang);
    pt = qmul(clip(longint'($signed(t.pitch_set)) - longint'($signed(t.pitch_ang))), kang);
    r = rate_pid(rt, $signed(t.roll_g), roll_int, roll_last, ktp, kti, ktd);
    p = rate_pid(pt, $signed(t.pitch_g), pitch_int, pitch_last, ktp, kti, ktd);
    y = rate_pid($signed(t.yaw_set), $signed(t.yaw_g), yaw_int, yaw_last, kyp, kyi, 0);
    base = 1000 * 65536;
    m.fl = motor_word(base + r + p - y);
    m.fr = motor_word(base - r + p + y);
    m.rl = motor_word(base + r - p + y);
    m.rr = motor_word(base - r - p - y);
    return m;
  endfunction

  function automatic int gap_len();
    if (!gaps_on) return 0;
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // driver: present the next tick, hold it until accepted
  int drive_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_motors.push_back(predict_motors(pending_ticks.pop_front()));
        drive_gap = gap_len();
      end
      if (!in_valid || !in_stall) begin
        if (drive_gap > 0 || pending_ticks.size() == 0) begin
          if (drive_gap > 0) drive_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_roll_setpoint <= pending_ticks[0].roll_set;
          in_pitch_setpoint <= pending_ticks[0].pitch_set;
          in_yaw_rate_setpoint <= pending_ticks[0].yaw_set;
          in_roll_angle <= pending_ticks[0].roll_ang;
          in_pitch_angle <= pending_ticks[0].pitch_ang;
          in_roll_gyro <= pending_ticks[0].roll_g;
          in_pitch_gyro <= pending_ticks[0].pitch_g;
          in_yaw_gyro <= pending_ticks[0].yaw_g;
        end
      end
    end
  end

  // monitor: compare each delivered item with the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    motors_t exp_m;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_motors.size() == 0) begin
          $display("%0t: unexpected item fl=%h", $time, out_motor_front_left);
          errors++;
        end else begin
          exp_m = expected_motors.pop_front();
          if (out_motor_front_left !== exp_m.fl) begin
            $display("%0t: front_left exp %h got %h", $time, exp_m.fl, out_motor_front_left);
            errors++;
          end
          if (out_motor_front_right !== exp_m.fr) begin
            $display("%0t: front_right exp %h got %h", $time, exp_m.fr,
                     out_motor_front_right);
            errors++;
          end
          if (out_motor_rear_left !== exp_m.rl) begin
            $display("%0t: rear_left exp %h got %h", $time, exp_m.rl, out_motor_rear_left);
            errors++;
          end
          if (out_motor_rear_right !== exp_m.rr) begin
            $display("%0t: rear_right exp %h got %h", $time, exp_m.rr, out_motor_rear_right);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = gap_len();
        out_stall <= (stall_left > 0);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, longint unsigned value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 5'(idx) << 2;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_PERIOD:  dt_q = value & 64'h1FFFF;
      REG_ANGLE_P: kang = value & 64'h7FFFFFFF;
      REG_TILT_P:  ktp = value & 64'h7FFFFFFF;
      REG_TILT_I:  kti = value & 64'h7FFFFFFF;
      REG_TILT_D:  ktd = value & 64'h7FFFFFFF;
      REG_YAW_P:   kyp = value & 64'h7FFFFFFF;
      REG_YAW_I:   kyi = value & 64'h7FFFFFFF;
      default:     ilim = value & 64'h7FFFFFFF;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || expected_motors.size() != 0 || in_valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(2000)) - 1000) << 16;
      3: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic tick_t rand_tick(bit tame);
    tick_t t;
    if (tame) begin
      t.roll_set = 32'($signed($urandom_range(40)) - 20) << 16;
      t.pitch_set = 32'($signed($urandom_range(40)) - 20) << 16;
      t.yaw_set = 32'($signed($urandom_range(400)) - 200) << 16;
      t.roll_ang = t.roll_set + 32'($signed($urandom_range(600000)) - 300000);
      t.pitch_ang = t.pitch_set + 32'($signed($urandom_range(600000)) - 300000);
      t.roll_g = 32'($signed($urandom_range(6000000)) - 3000000);
      t.pitch_g = 32'($signed($urandom_range(6000000)) - 3000000);
      t.yaw_g = 32'($signed($urandom_range(6000000)) - 3000000);
    end else begin
      t.roll_set = rand_value();  t.pitch_set = rand_value();
      t.yaw_set = rand_value();   t.roll_ang = rand_value();
      t.pitch_ang = rand_value(); t.roll_g = rand_value();
      t.pitch_g = rand_value();  t.yaw_g = rand_value();
    end
    return t;
  endfunction

  function automatic tick_t same_tick(logic [31:0] v, logic [31:0] w);
    tick_t t;
    t.roll_set = v; t.pitch_set = v; t.yaw_set = v; t.roll_ang = w;
    t.pitch_ang = w; t.roll_g = w; t.pitch_g = w; t.yaw_g = w;
    return t;
  endfunction

  function automatic longint unsigned rand_gain();
    case ($urandom_range(4))
      0: return 0;
      1: return 64'h7FFFFFFF;
      2: return $urandom_range(300000);
      default: return $urandom & 32'h7FFFFFFF;
    endcase
  endfunction

  initial begin
    dt_q = 164; kang = 294912; ktp = 9830; kti = 3277; ktd = 655;
    kyp = 29491; kyi = 6554; ilim = 26214400;
    roll_int = 0; roll_last = 0; pitch_int = 0; pitch_last = 0; yaw_int = 0; yaw_last = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes at reset gains
    pending_ticks.push_back(same_tick(32'h0, 32'h0));
    pending_ticks.push_back(same_tick(32'h7FFFFFFF, 32'h80000000));
    pending_ticks.push_back(same_tick(32'h80000000, 32'h7FFFFFFF));
    pending_ticks.push_back(same_tick(32'hFFFFFFFF, 32'h00000001));
    pending_ticks.push_back(same_tick(32'h00010000, 32'h00010000));
    pending_ticks.push_back(same_tick(32'hAAAAAAAA, 32'h55555555));
    wait_drained();

    // zero period freezes integrals; derivative saturates, or is zero when unchanged
    write_reg(REG_PERIOD, 0);
    pending_ticks.push_back(same_tick(32'h00050000, 32'h0));
    pending_ticks.push_back(same_tick(32'h00050000, 32'h0));
    pending_ticks.push_back(same_tick(32'hFFF00000, 32'h0));
    wait_drained();

    // extreme gains and period, tiny limit
    write_reg(REG_PERIOD, MAX_PERIOD);
    write_reg(REG_ANGLE_P, 64'h7FFFFFFF);
    write_reg(REG_TILT_P, 64'h7FFFFFFF);
    write_reg(REG_TILT_I, 64'h7FFFFFFF);
    write_reg(REG_TILT_D, 64'h7FFFFFFF);
    write_reg(REG_YAW_P, 64'h7FFFFFFF);
    write_reg(REG_YAW_I, 64'h7FFFFFFF);
    write_reg(REG_ILIM, 0);
    for (int i = 0; i < 6; i++) pending_ticks.push_back(rand_tick(i[0]));
    wait_drained();
    write_reg(REG_PERIOD, 64'h1FFFF);
    write_reg(REG_ILIM, 64'h7FFFFFFF);
    for (int i = 0; i < 4; i++) pending_ticks.push_back(rand_tick(1'b0));
    wait_drained();

    // random phases: the second at reset settings, later ones with random settings; the first one runs without gaps
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph != 0);
      if (ph == 1) begin
        write_reg(REG_PERIOD, 164); write_reg(REG_ANGLE_P, 294912);
        write_reg(REG_TILT_P, 9830); write_reg(REG_TILT_I, 3277);
        write_reg(REG_TILT_D, 655); write_reg(REG_YAW_P, 29491);
        write_reg(REG_YAW_I, 6554); write_reg(REG_ILIM, 26214400);
      end else if (ph > 1) begin
        write_reg(REG_PERIOD, ($urandom_range(3) == 0) ? $urandom_range(1)
                                                       : $urandom_range(MAX_PERIOD, 1));
        write_reg(REG_ANGLE_P, rand_gain());
        write_reg(REG_TILT_P, rand_gain());
        write_reg(REG_TILT_I, rand_gain());
        write_reg(REG_TILT_D, rand_gain());
        write_reg(REG_YAW_P, rand_gain());
        write_reg(REG_YAW_I, rand_gain());
        write_reg(REG_ILIM, ($urandom_range(1)) ? $urandom_range(100000000) : rand_gain());
      end
      for (int i = 0; i < 50; i++) pending_ticks.push_back(rand_tick($urandom_range(3) != 0));
      wait_drained();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== cascaded_attitude_pid_mixer_unit.f =====
sv/capm_pkg.sv
sv/capm_lane.sv
sv/capm_mixer.sv
sv/cascaded_attitude_pid_mixer_unit.sv
tb/cascaded_attitude_pid_mixer_unit_test.sv
